// ===== rtl/frns_pkg.sv =====
package frns_pkg;

  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int MAX_NEIGHBORS_DEF = 64;

  localparam int IDX_W       = 10;
  localparam int COORD_W     = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int RAD_W       = 52;
  localparam int PCOUNT_W    = 11;
  localparam int KIND_W      = 2;
  localparam int NCOUNT_W    = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 52;
  localparam int NUM_AXES    = 3;

  localparam logic [RAD_W-1:0]    RADIUS_RESET = 52'd16777216;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 11'd1024;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_SQ      = 2'd0,
    CFG_PARTICLE_COUNT = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } seq_state_t;

  typedef struct packed {
    logic              valid;
    logic              is_ref;
    logic              fin;
    logic              bad;
    logic [KIND_W-1:0] kind;
  } tok_t;

  typedef struct packed {
    logic [IDX_W-1:0] query_idx;
    logic [RAD_W-1:0] radius_sq;
  } ctl_t;

endpackage

// ===== rtl/frns_in_if.sv =====
interface frns_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [frns_pkg::IDX_W-1:0]          particle_index;
  logic signed [frns_pkg::COORD_W-1:0] pos_x;
  logic signed [frns_pkg::COORD_W-1:0] pos_y;
  logic signed [frns_pkg::COORD_W-1:0] pos_z;
  logic [frns_pkg::KIND_W-1:0]         particle_kind;

  modport source (output valid, operation, particle_index, pos_x, pos_y, pos_z,
                  particle_kind, input ready);
  modport sink (input valid, operation, particle_index, pos_x, pos_y, pos_z,
                particle_kind, output ready);
endinterface

// ===== rtl/frns_out_if.sv =====
interface frns_out_if;
  logic                          valid;
  logic                          ready;
  logic [frns_pkg::IDX_W-1:0]    neighbor_index;
  logic                          neighbor_kind;
  logic                          has_neighbor;
  logic                          last;
  logic                          overflow;
  logic [frns_pkg::NCOUNT_W-1:0] fluid_count;
  logic [frns_pkg::NCOUNT_W-1:0] wall_count;
  logic                          bad_index;

  modport source (output valid, neighbor_index, neighbor_kind, has_neighbor, last,
                  overflow, fluid_count, wall_count, bad_index, input ready);
  modport sink (input valid, neighbor_index, neighbor_kind, has_neighbor, last,
                overflow, fluid_count, wall_count, bad_index, output ready);
endinterface

// ===== rtl/frns_cfg_if.sv =====
interface frns_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [frns_pkg::CFG_IDX_W-1:0]  index;
  logic [frns_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/frns_seq.sv =====
module frns_seq #(
  parameter int MAX_PARTICLES = frns_pkg::MAX_PARTICLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  frns_in_if.sink                  in_ch,
  frns_cfg_if.sink                 cfg_ch,
  input  logic                     adv,
  input  logic                     done,
  output logic                     wr_en,
  output logic [$clog2(MAX_PARTICLES)-1:0] wr_addr,
  output frns_pkg::tok_t           tag_o,
  output logic [$clog2(MAX_PARTICLES)-1:0] idx_o,
  output frns_pkg::ctl_t           ctl_o
);

  localparam int ADDR_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W  = ADDR_W + 1;

  frns_pkg::seq_state_t state_r, state_nxt;

  logic [frns_pkg::RAD_W-1:0]    radius_r;
  logic [frns_pkg::PCOUNT_W-1:0] pcount_r;
  logic [frns_pkg::IDX_W-1:0]    q_r;
  logic [CNT_W-1:0]              count_r;
  logic [ADDR_W-1:0]             scan_r;
  frns_pkg::tok_t                tok_r, tok_nxt;
  logic [ADDR_W-1:0]             idx_r, idx_nxt;
  logic [frns_pkg::KIND_W-1:0]   kind_rd_r;
  logic [frns_pkg::KIND_W-1:0]   kind_mem [MAX_PARTICLES];

  logic             acc;
  logic             is_query;
  logic [CNT_W-1:0] count_w;
  logic             bad_w;
  logic             last_j;

  assign acc      = in_ch.valid && in_ch.ready;
  assign is_query = in_ch.operation == frns_pkg::OP_QUERY;
  assign count_w  = (32'(pcount_r) < 32'(MAX_PARTICLES)) ? CNT_W'(pcount_r)
                                                         : CNT_W'(MAX_PARTICLES);
  assign bad_w    = 32'(in_ch.particle_index) >= 32'(count_w);
  assign last_j   = (CNT_W'(scan_r) + CNT_W'(1)) == count_r;
  assign wr_addr  = ADDR_W'(in_ch.particle_index);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frns_pkg::ST_IDLE: begin
        if (acc && is_query) begin
          state_nxt = bad_w ? frns_pkg::ST_WAIT : frns_pkg::ST_SCAN;
        end
      end
      frns_pkg::ST_SCAN: begin
        if (adv && last_j) begin
          state_nxt = frns_pkg::ST_WAIT;
        end
      end
      frns_pkg::ST_WAIT: begin
        if (done) begin
          state_nxt = frns_pkg::ST_IDLE;
        end
      end
      default: state_nxt = frns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    wr_en       = 1'b0;
    tok_nxt     = '0;
    idx_nxt     = scan_r;
    unique case (state_r)
      frns_pkg::ST_IDLE: begin
        in_ch.ready = adv;
        wr_en       = acc && !is_query &&
                      (32'(in_ch.particle_index) < 32'(MAX_PARTICLES));
        idx_nxt     = ADDR_W'(in_ch.particle_index);
        if (acc && is_query) begin
          tok_nxt.valid  = 1'b1;
          tok_nxt.is_ref = !bad_w;
          tok_nxt.fin    = bad_w;
          tok_nxt.bad    = bad_w;
        end
      end
      frns_pkg::ST_SCAN: begin
        tok_nxt.valid = 1'b1;
        tok_nxt.fin   = last_j;
      end
      frns_pkg::ST_WAIT: begin
        tok_nxt = '0;
      end
      default: tok_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= frns_pkg::ST_IDLE;
      radius_r <= frns_pkg::RADIUS_RESET;
      pcount_r <= frns_pkg::PCOUNT_RESET;
      tok_r    <= '0;
      scan_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          frns_pkg::CFG_RADIUS_SQ:      radius_r <= cfg_ch.data[frns_pkg::RAD_W-1:0];
          frns_pkg::CFG_PARTICLE_COUNT: pcount_r <= cfg_ch.data[frns_pkg::PCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (adv) begin
        tok_r <= tok_nxt;
      end
      if (acc && is_query) begin
        scan_r <= '0;
      end else if (state_r == frns_pkg::ST_SCAN && adv) begin
        scan_r <= scan_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_query) begin
      q_r     <= in_ch.particle_index;
      count_r <= count_w;
    end
    if (adv) begin
      idx_r     <= idx_nxt;
      kind_rd_r <= kind_mem[idx_nxt];
    end
    if (wr_en) begin
      kind_mem[wr_addr] <= in_ch.particle_kind;
    end
  end

  always_comb begin
    tag_o      = tok_r;
    tag_o.kind = kind_rd_r;
  end

  assign idx_o           = idx_r;
  assign ctl_o.query_idx = q_r;
  assign ctl_o.radius_sq = radius_r;

endmodule

// ===== rtl/frns_cell.sv =====
module frns_cell #(
  parameter int MAX_PARTICLES = frns_pkg::MAX_PARTICLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_PARTICLES)-1:0]    wr_addr,
  input  logic [frns_pkg::COORD_W-1:0]        wr_data,
  input  frns_pkg::tok_t                      tag_i,
  input  logic [$clog2(MAX_PARTICLES)-1:0]    idx_i,
  input  logic [frns_pkg::SUM_W-1:0]          sum_i,
  output frns_pkg::tok_t                      tag_o,
  output logic [$clog2(MAX_PARTICLES)-1:0]    idx_o,
  output logic [frns_pkg::SUM_W-1:0]          sum_o
);

  localparam int ADDR_W = $clog2(MAX_PARTICLES);

  logic [frns_pkg::COORD_W-1:0] mem [MAX_PARTICLES];
  logic [frns_pkg::COORD_W-1:0] rd_r;
  logic [frns_pkg::COORD_W-1:0] ref_r;

  frns_pkg::tok_t tag1_r, tag2_r, tag3_r, tag4_r;
  logic [ADDR_W-1:0] idx1_r, idx2_r, idx3_r, idx4_r;
  logic [frns_pkg::SUM_W-1:0] sum1_r, sum2_r, sum3_r, sum4_r;

  logic signed [frns_pkg::DIFF_W-1:0]   diff_r, diff_nxt;
  logic signed [2*frns_pkg::DIFF_W-1:0] prod;
  logic [frns_pkg::SQ_W-1:0]            sq_r;

  assign diff_nxt = $signed({rd_r[frns_pkg::COORD_W-1], rd_r}) -
                    $signed({ref_r[frns_pkg::COORD_W-1], ref_r});
  assign prod     = diff_r * diff_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      rd_r <= mem[idx_i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else if (adv) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r <= idx_i;
      idx2_r <= idx1_r;
      idx3_r <= idx2_r;
      idx4_r <= idx3_r;
      sum1_r <= sum_i;
      sum2_r <= sum1_r;
      sum3_r <= sum2_r;
      sum4_r <= sum3_r + frns_pkg::SUM_W'(sq_r);
      diff_r <= diff_nxt;
      sq_r   <= prod[frns_pkg::SQ_W-1:0];
      if (tag1_r.valid && tag1_r.is_ref) begin
        ref_r <= rd_r;
      end
    end
  end

  assign tag_o = tag4_r;
  assign idx_o = idx4_r;
  assign sum_o = sum4_r;

endmodule

// ===== rtl/frns_tail.sv =====
module frns_tail #(
  parameter int MAX_PARTICLES = frns_pkg::MAX_PARTICLES_DEF,
  parameter int MAX_NEIGHBORS = frns_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  frns_pkg::tok_t                   tag_i,
  input  logic [$clog2(MAX_PARTICLES)-1:0] idx_i,
  input  logic [frns_pkg::SUM_W-1:0]       sum_i,
  input  frns_pkg::ctl_t                   ctl_i,
  frns_out_if.source                       out_ch,
  output logic                             adv,
  output logic                             done
);

  localparam int ADDR_W = $clog2(MAX_PARTICLES);
  localparam int LST_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam int IDX_W  = frns_pkg::IDX_W;
  localparam int RAD_W  = frns_pkg::RAD_W;

  typedef struct packed {
    logic [frns_pkg::IDX_W-1:0]    neighbor_index;
    logic                          neighbor_kind;
    logic                          has_neighbor;
    logic                          last;
    logic                          overflow;
    logic [frns_pkg::NCOUNT_W-1:0] fluid_count;
    logic [frns_pkg::NCOUNT_W-1:0] wall_count;
    logic                          bad_index;
  } res_t;

  res_t res_r, res_nxt;
  logic out_valid_r;

  logic                          pend_vld_r;
  logic [ADDR_W-1:0]             pend_idx_r;
  logic                          pend_kind_r;
  logic [LST_W-1:0]              listed_r;
  logic [frns_pkg::NCOUNT_W-1:0] fluid_r;
  logic [frns_pkg::NCOUNT_W-1:0] wall_r;
  logic                          ovf_r;
  logic                          fin_r;
  logic                          bad_r;

  logic hit, room, out_space, push_hit, take;

  assign hit = tag_i.valid && !tag_i.is_ref && !tag_i.bad && !tag_i.kind[1] &&
               (32'(idx_i) != 32'(ctl_i.query_idx)) &&
               (RAD_W'(sum_i) <= ctl_i.radius_sq);
  assign room      = listed_r < LST_W'(MAX_NEIGHBORS);
  assign out_space = !out_valid_r || out_ch.ready;
  assign push_hit  = hit && room && pend_vld_r;
  assign adv       = !(push_hit && !out_space);
  assign take      = tag_i.valid && adv;
  assign done      = fin_r && out_space;

  always_comb begin
    res_nxt = '0;
    if (fin_r) begin
      res_nxt.neighbor_index = pend_vld_r ? IDX_W'(pend_idx_r) : '0;
      res_nxt.neighbor_kind  = pend_vld_r && pend_kind_r;
      res_nxt.has_neighbor   = pend_vld_r;
      res_nxt.last           = 1'b1;
      res_nxt.overflow       = ovf_r;
      res_nxt.fluid_count    = fluid_r;
      res_nxt.wall_count     = wall_r;
      res_nxt.bad_index      = bad_r;
    end else begin
      res_nxt.neighbor_index = IDX_W'(pend_idx_r);
      res_nxt.neighbor_kind  = pend_kind_r;
      res_nxt.has_neighbor   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      listed_r    <= '0;
      fluid_r     <= '0;
      wall_r      <= '0;
      ovf_r       <= 1'b0;
      fin_r       <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      if ((push_hit || fin_r) && out_space) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (done) begin
        pend_vld_r <= 1'b0;
        listed_r   <= '0;
        fluid_r    <= '0;
        wall_r     <= '0;
        ovf_r      <= 1'b0;
        fin_r      <= 1'b0;
        bad_r      <= 1'b0;
      end else if (take) begin
        if (hit) begin
          if (tag_i.kind[0]) begin
            wall_r <= wall_r + frns_pkg::NCOUNT_W'(1);
          end else begin
            fluid_r <= fluid_r + frns_pkg::NCOUNT_W'(1);
          end
          if (room) begin
            pend_vld_r <= 1'b1;
            listed_r   <= listed_r + LST_W'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end
        if (tag_i.fin) begin
          fin_r <= 1'b1;
          bad_r <= tag_i.bad;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((push_hit || fin_r) && out_space) begin
      res_r <= res_nxt;
    end
    if (take && hit && room) begin
      pend_idx_r  <= idx_i;
      pend_kind_r <= tag_i.kind[0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.neighbor_index = res_r.neighbor_index;
  assign out_ch.neighbor_kind  = res_r.neighbor_kind;
  assign out_ch.has_neighbor   = res_r.has_neighbor;
  assign out_ch.last           = res_r.last;
  assign out_ch.overflow       = res_r.overflow;
  assign out_ch.fluid_count    = res_r.fluid_count;
  assign out_ch.wall_count     = res_r.wall_count;
  assign out_ch.bad_index      = res_r.bad_index;

endmodule

// ===== rtl/fixed_radius_neighbor_search.sv =====
// channel  dir  handshake    carries
// in_ch    in   valid/ready  operation, particle_index, pos_x/y/z, particle_kind
// out_ch   out  valid/ready  neighbor_index/kind, has_neighbor, last, overflow, counts, bad_index
// cfg_ch   in   valid/ready  index (0 radius_squared, 1 particle_count), data
// A load is written to the stores when accepted. A query scans min(particle_count, MAX_PARTICLES)
// slots: one slot enters the three-cell distance chain per cycle while the output does not stall
// (one read port per coordinate store, four stages per cell), then the final item is formed.
// rst_n clears control state and the registers to their reset values; stores keep contents.
// A stalled output holds the whole chain; the next item is taken once the last result of
// a query sits in the output register.
module fixed_radius_neighbor_search #(
  parameter int MAX_PARTICLES = frns_pkg::MAX_PARTICLES_DEF,
  parameter int MAX_NEIGHBORS = frns_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  frns_in_if.sink    in_ch,
  frns_out_if.source out_ch,
  frns_cfg_if.sink   cfg_ch
);

  localparam int ADDR_W = $clog2(MAX_PARTICLES);
  localparam int NAX    = frns_pkg::NUM_AXES;

  logic              adv;
  logic              done;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  frns_pkg::ctl_t    ctl;

  frns_pkg::tok_t             tag_c [NAX+1];
  logic [ADDR_W-1:0]          idx_c [NAX+1];
  logic [frns_pkg::SUM_W-1:0] sum_c [NAX+1];
  logic [frns_pkg::COORD_W-1:0] wr_coord [NAX];

  assign wr_coord[0] = in_ch.pos_x;
  assign wr_coord[1] = in_ch.pos_y;
  assign wr_coord[2] = in_ch.pos_z;
  assign sum_c[0]    = '0;

  frns_seq #(.MAX_PARTICLES(MAX_PARTICLES)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .adv     (adv),
    .done    (done),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .tag_o   (tag_c[0]),
    .idx_o   (idx_c[0]),
    .ctl_o   (ctl)
  );

  for (genvar g = 0; g < NAX; g++) begin : g_cell
    frns_cell #(.MAX_PARTICLES(MAX_PARTICLES)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_coord[g]),
      .tag_i   (tag_c[g]),
      .idx_i   (idx_c[g]),
      .sum_i   (sum_c[g]),
      .tag_o   (tag_c[g+1]),
      .idx_o   (idx_c[g+1]),
      .sum_o   (sum_c[g+1])
    );
  end

  frns_tail #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_tail (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (tag_c[NAX]),
    .idx_i  (idx_c[NAX]),
    .sum_i  (sum_c[NAX]),
    .ctl_i  (ctl),
    .out_ch (out_ch),
    .adv    (adv),
    .done   (done)
  );

endmodule

// ===== rtl/frns_chk.sv =====
module frns_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [frns_pkg::IDX_W-1:0]    out_neighbor_index,
  input logic                          out_has_neighbor,
  input logic                          out_last,
  input logic                          out_overflow,
  input logic [frns_pkg::NCOUNT_W-1:0] out_fluid_count,
  input logic [frns_pkg::NCOUNT_W-1:0] out_wall_count,
  input logic                          out_bad_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_neighbor_index) &&
                                $stable(out_last))
    else $error("output item changed while stalled");

  a_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_has_neighbor && !out_bad_index && !out_overflow &&
                               out_fluid_count == '0 && out_wall_count == '0)
    else $error("non-final item carries summary fields");

  a_bad_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bad_index || out_overflow) |->
      out_last && (out_has_neighbor == out_overflow))
    else $error("bad index or overflow on malformed item");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == frns_pkg::OP_QUERY |=> !in_ready)
    else $error("input taken during a query");

endmodule

bind fixed_radius_neighbor_search frns_chk u_frns_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_operation       (in_ch.operation),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_neighbor_index (out_ch.neighbor_index),
  .out_has_neighbor   (out_ch.has_neighbor),
  .out_last           (out_ch.last),
  .out_overflow       (out_ch.overflow),
  .out_fluid_count    (out_ch.fluid_count),
  .out_wall_count     (out_ch.wall_count),
  .out_bad_index      (out_ch.bad_index)
);
